// ===== design/ccs_pkg.sv =====
// Shared types and constants for the cell counting sort block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package ccs_pkg;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int CELL_W   = 12;
    localparam int POS_W    = 13;
    localparam int VALUE_W  = 13;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 13;

    localparam logic [CFG_W-1:0] CELL_COUNT_RST = 13'd4096;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD        = 3'd1;
    localparam logic [OP_W-1:0] OP_BUILD       = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_SORTED = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_START  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_CELL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_POS  = 2'd3;

    // How an accepted item is handled
    typedef enum logic [1:0] {
        K_IMM,
        K_READ,
        K_CLEAR,
        K_BUILD
    } kind_t;

    // Source of a result pushed into the output queue
    typedef enum logic [1:0] {
        PK_IMM,
        PK_READ,
        PK_OK,
        PK_CELL_ERR
    } push_kind_t;

    // Walk index update
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_TOP
    } idx_op_t;

    // Cell start memory read address select
    typedef enum logic [1:0] {
        CSR_NONE,
        CSR_IDX,
        CSR_CELL
    } cs_rd_t;

    // Cell start memory write select
    typedef enum logic [2:0] {
        CSW_NONE,
        CSW_ZERO,
        CSW_INC,
        CSW_SUM,
        CSW_TOTAL,
        CSW_DEC
    } cs_wr_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;
        logic       push;
        push_kind_t push_kind;
        idx_op_t    idx_op;
        logic       sum_clr;
        logic       pc_rd;
        cs_rd_t     cs_rd;
        cs_wr_t     cs_wr;
        logic       set_sorted;
    } ccs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        kind_t kind;
        logic  q_full;
        logic  n_zero;
        logic  cc_zero;
        logic  idx_sweep_end;
        logic  idx_n_last;
        logic  idx_cc_last;
        logic  idx_zero;
        logic  chk_bad;
    } ccs_stat_t;

    // Controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CLEAR,
        S_CHK_RD,
        S_CHK_TST,
        S_ZERO,
        S_CNT_RD,
        S_CNT_CS,
        S_CNT_WR,
        S_PFX_RD,
        S_PFX_WR,
        S_TOTAL,
        S_PLC_RD,
        S_PLC_CS,
        S_PLC_WR
    } state_t;

endpackage

// ===== design/ccs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while no read is issued. No dependencies.
module ccs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ccs_ctrl.sv =====
// Controller state machine of the cell counting sort block.
// Depends on ccs_pkg; drives the datapath through ccs_cmd_t.
module ccs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ccs_pkg::ccs_stat_t stat,
    output ccs_pkg::ccs_cmd_t  cmd
);

    ccs_pkg::state_t state_reg;
    ccs_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ccs_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ccs_pkg::S_IDLE) && !stat.q_full;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ccs_pkg::S_INIT:
            begin
                // Zero the cell start store after reset
                cmd.cs_wr = ccs_pkg::CSW_ZERO;
                if (stat.idx_sweep_end)
                begin
                    cmd.idx_op = ccs_pkg::IDX_ZERO;
                    state_next = ccs_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_INC;
                end
            end
            ccs_pkg::S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.take = 1'b1;
                    unique case (stat.kind)
                        ccs_pkg::K_IMM:
                        begin
                            cmd.push      = 1'b1;
                            cmd.push_kind = ccs_pkg::PK_IMM;
                        end
                        ccs_pkg::K_READ:
                        begin
                            state_next = ccs_pkg::S_READ;
                        end
                        ccs_pkg::K_CLEAR:
                        begin
                            cmd.idx_op = ccs_pkg::IDX_ZERO;
                            state_next = ccs_pkg::S_CLEAR;
                        end
                        ccs_pkg::K_BUILD:
                        begin
                            cmd.idx_op = ccs_pkg::IDX_ZERO;
                            if (!stat.n_zero)
                            begin
                                state_next = ccs_pkg::S_CHK_RD;
                            end
                            else if (stat.cc_zero)
                            begin
                                state_next = ccs_pkg::S_TOTAL;
                            end
                            else
                            begin
                                state_next = ccs_pkg::S_ZERO;
                            end
                        end
                        default:
                        begin
                            state_next = ccs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ccs_pkg::S_READ:
            begin
                cmd.push      = 1'b1;
                cmd.push_kind = ccs_pkg::PK_READ;
                state_next    = ccs_pkg::S_IDLE;
            end
            ccs_pkg::S_CLEAR:
            begin
                cmd.cs_wr = ccs_pkg::CSW_ZERO;
                if (stat.idx_sweep_end)
                begin
                    cmd.idx_op    = ccs_pkg::IDX_ZERO;
                    cmd.push      = 1'b1;
                    cmd.push_kind = ccs_pkg::PK_OK;
                    state_next    = ccs_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_INC;
                end
            end
            ccs_pkg::S_CHK_RD:
            begin
                cmd.pc_rd  = 1'b1;
                state_next = ccs_pkg::S_CHK_TST;
            end
            ccs_pkg::S_CHK_TST:
            begin
                // Abort the build on a stored cell beyond the grid
                if (stat.chk_bad)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_kind = ccs_pkg::PK_CELL_ERR;
                    state_next    = ccs_pkg::S_IDLE;
                end
                else if (stat.idx_n_last)
                begin
                    cmd.idx_op = ccs_pkg::IDX_ZERO;
                    state_next = stat.cc_zero ? ccs_pkg::S_TOTAL : ccs_pkg::S_ZERO;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_INC;
                    state_next = ccs_pkg::S_CHK_RD;
                end
            end
            ccs_pkg::S_ZERO:
            begin
                cmd.cs_wr = ccs_pkg::CSW_ZERO;
                if (stat.idx_cc_last)
                begin
                    cmd.idx_op = ccs_pkg::IDX_ZERO;
                    state_next = stat.n_zero ? ccs_pkg::S_TOTAL : ccs_pkg::S_CNT_RD;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_INC;
                end
            end
            ccs_pkg::S_CNT_RD:
            begin
                cmd.pc_rd  = 1'b1;
                state_next = ccs_pkg::S_CNT_CS;
            end
            ccs_pkg::S_CNT_CS:
            begin
                cmd.cs_rd  = ccs_pkg::CSR_CELL;
                state_next = ccs_pkg::S_CNT_WR;
            end
            ccs_pkg::S_CNT_WR:
            begin
                cmd.cs_wr = ccs_pkg::CSW_INC;
                if (stat.idx_n_last)
                begin
                    cmd.idx_op  = ccs_pkg::IDX_ZERO;
                    cmd.sum_clr = 1'b1;
                    state_next  = ccs_pkg::S_PFX_RD;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_INC;
                    state_next = ccs_pkg::S_CNT_RD;
                end
            end
            ccs_pkg::S_PFX_RD:
            begin
                cmd.cs_rd  = ccs_pkg::CSR_IDX;
                state_next = ccs_pkg::S_PFX_WR;
            end
            ccs_pkg::S_PFX_WR:
            begin
                cmd.cs_wr = ccs_pkg::CSW_SUM;
                if (stat.idx_cc_last)
                begin
                    state_next = ccs_pkg::S_TOTAL;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_INC;
                    state_next = ccs_pkg::S_PFX_RD;
                end
            end
            ccs_pkg::S_TOTAL:
            begin
                // Store the particle count after the last cell
                cmd.cs_wr = ccs_pkg::CSW_TOTAL;
                if (stat.n_zero)
                begin
                    cmd.set_sorted = 1'b1;
                    cmd.push       = 1'b1;
                    cmd.push_kind  = ccs_pkg::PK_OK;
                    state_next     = ccs_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_TOP;
                    state_next = ccs_pkg::S_PLC_RD;
                end
            end
            ccs_pkg::S_PLC_RD:
            begin
                cmd.pc_rd  = 1'b1;
                state_next = ccs_pkg::S_PLC_CS;
            end
            ccs_pkg::S_PLC_CS:
            begin
                cmd.cs_rd  = ccs_pkg::CSR_CELL;
                state_next = ccs_pkg::S_PLC_WR;
            end
            ccs_pkg::S_PLC_WR:
            begin
                cmd.cs_wr = ccs_pkg::CSW_DEC;
                if (stat.idx_zero)
                begin
                    cmd.set_sorted = 1'b1;
                    cmd.push       = 1'b1;
                    cmd.push_kind  = ccs_pkg::PK_OK;
                    state_next     = ccs_pkg::S_IDLE;
                end
                else
                begin
                    cmd.idx_op = ccs_pkg::IDX_DEC;
                    state_next = ccs_pkg::S_PLC_RD;
                end
            end
            default:
            begin
                state_next = ccs_pkg::S_INIT;
            end
        endcase
    end

endmodule

// ===== design/ccs_datapath.sv =====
// Datapath of the cell counting sort block: stores, counters, walk index,
// prefix sum and the two-entry result queue.
// Depends on ccs_pkg and ccs_ram; controlled through ccs_cmd_t.
module ccs_datapath #(
    parameter int MAX_PARTICLES = 4096,
    parameter int MAX_CELLS     = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ccs_pkg::ccs_cmd_t             cmd,
    output ccs_pkg::ccs_stat_t            stat,
    input  logic [ccs_pkg::OP_W-1:0]      in_op,
    input  logic [ccs_pkg::CELL_W-1:0]    in_cell,
    input  logic [ccs_pkg::POS_W-1:0]     in_pos,
    input  logic                          cfg_valid,
    input  logic [ccs_pkg::CFG_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ccs_pkg::VALUE_W-1:0]   out_value,
    output logic [ccs_pkg::STATUS_W-1:0]  out_status
);

    localparam int VW     = ccs_pkg::VALUE_W;
    localparam int CW     = ccs_pkg::CFG_W;
    localparam int SW     = ccs_pkg::STATUS_W;
    localparam int PC_AW  = $clog2(MAX_PARTICLES);
    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int CS_AW  = $clog2(MAX_CELLS + 1);
    localparam int IDX_W  = (CS_AW > CNT_W) ? CS_AW : CNT_W;

    typedef struct packed {
        logic [VW-1:0] value;
        logic [SW-1:0] status;
    } res_t;

    // Registers
    logic [CW-1:0]    cell_count_reg;
    logic [CNT_W-1:0] loaded_reg;
    logic [CNT_W-1:0] loaded_next;
    logic [CNT_W-1:0] sorted_reg;
    logic [CNT_W-1:0] sorted_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [CNT_W-1:0] sum_reg;
    logic [CNT_W-1:0] sum_next;
    logic [ccs_pkg::OP_W-1:0] op_reg;
    logic [SW-1:0]    rd_stat_reg;
    logic [SW-1:0]    rd_stat_next;

    // Memory ports
    logic [ccs_pkg::CELL_W-1:0] pc_rdata;
    logic             pc_we;
    logic [CNT_W-1:0] cs_rdata;
    logic             cs_we;
    logic [CS_AW-1:0] cs_waddr;
    logic [CNT_W-1:0] cs_wdata;
    logic             cs_re;
    logic [CS_AW-1:0] cs_raddr;
    logic [PC_AW-1:0] si_rdata;
    logic             si_we;
    logic             si_re;
    logic [CNT_W-1:0] cs_dec;

    // Decode of the offered item
    ccs_pkg::kind_t item_kind;
    logic          load_full;
    logic          cell_bad;
    logic          cc_bad;
    logic          rs_ok;
    logic          start_ok;
    logic [SW-1:0] imm_status;
    logic          load_ok;

    // Result queue
    res_t        q_mem_reg [2];
    logic        q_wr_reg;
    logic        q_rd_reg;
    logic [1:0]  q_cnt_reg;
    logic [1:0]  q_cnt_next;
    logic        q_pop;
    res_t        res;

    assign load_full = 32'(loaded_reg) >= MAX_PARTICLES;
    assign cell_bad  = CW'(in_cell) >= cell_count_reg;
    assign cc_bad    = 32'(cell_count_reg) > MAX_CELLS;
    assign rs_ok     = (32'(in_pos) < 32'(sorted_reg)) && (32'(in_pos) < MAX_PARTICLES);
    assign start_ok  = (in_pos <= cell_count_reg) && (32'(in_pos) <= MAX_CELLS);
    assign load_ok   = cmd.take && (in_op == ccs_pkg::OP_LOAD) && !load_full && !cell_bad;

    // Classify the offered item and form the immediate status
    always_comb
    begin
        item_kind    = ccs_pkg::K_IMM;
        imm_status   = ccs_pkg::STAT_OK;
        rd_stat_next = ccs_pkg::STAT_OK;
        unique case (in_op)
            ccs_pkg::OP_CLEAR:
            begin
                item_kind = ccs_pkg::K_CLEAR;
            end
            ccs_pkg::OP_LOAD:
            begin
                if (load_full)
                begin
                    imm_status = ccs_pkg::STAT_FULL;
                end
                else if (cell_bad)
                begin
                    imm_status = ccs_pkg::STAT_CELL;
                end
            end
            ccs_pkg::OP_BUILD:
            begin
                if (cc_bad)
                begin
                    imm_status = ccs_pkg::STAT_CELL;
                end
                else
                begin
                    item_kind = ccs_pkg::K_BUILD;
                end
            end
            ccs_pkg::OP_READ_SORTED:
            begin
                item_kind    = ccs_pkg::K_READ;
                rd_stat_next = rs_ok ? ccs_pkg::STAT_OK : ccs_pkg::STAT_POS;
            end
            ccs_pkg::OP_READ_START:
            begin
                item_kind    = ccs_pkg::K_READ;
                rd_stat_next = start_ok ? ccs_pkg::STAT_OK : ccs_pkg::STAT_POS;
            end
            default:
            begin
                item_kind = ccs_pkg::K_IMM;
            end
        endcase
    end

    // Status towards the controller
    assign stat.kind          = item_kind;
    assign stat.q_full        = (q_cnt_reg == 2'd2);
    assign stat.n_zero        = (loaded_reg == '0);
    assign stat.cc_zero       = (cell_count_reg == '0);
    assign stat.idx_sweep_end = (32'(idx_reg) == MAX_CELLS);
    assign stat.idx_n_last    = ((32'(idx_reg) + 32'd1) == 32'(loaded_reg));
    assign stat.idx_cc_last   = ((32'(idx_reg) + 32'd1) == 32'(cell_count_reg));
    assign stat.idx_zero      = (idx_reg == '0);
    assign stat.chk_bad       = CW'(pc_rdata) >= cell_count_reg;

    // Walk index, prefix sum and counts
    always_comb
    begin
        unique case (cmd.idx_op)
            ccs_pkg::IDX_HOLD: idx_next = idx_reg;
            ccs_pkg::IDX_ZERO: idx_next = '0;
            ccs_pkg::IDX_INC:  idx_next = idx_reg + 1'b1;
            ccs_pkg::IDX_DEC:  idx_next = idx_reg - 1'b1;
            ccs_pkg::IDX_TOP:  idx_next = IDX_W'(loaded_reg - 1'b1);
            default:           idx_next = idx_reg;
        endcase

        sum_next = sum_reg;
        if (cmd.sum_clr)
        begin
            sum_next = '0;
        end
        else if (cmd.cs_wr == ccs_pkg::CSW_SUM)
        begin
            sum_next = sum_reg + cs_rdata;
        end

        loaded_next = loaded_reg;
        sorted_next = sorted_reg;
        if (cmd.take && (in_op == ccs_pkg::OP_CLEAR))
        begin
            loaded_next = '0;
            sorted_next = '0;
        end
        else
        begin
            if (load_ok)
            begin
                loaded_next = loaded_reg + 1'b1;
            end
            if (cmd.set_sorted)
            begin
                sorted_next = loaded_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_count_reg <= ccs_pkg::CELL_COUNT_RST;
            loaded_reg     <= '0;
            sorted_reg     <= '0;
            idx_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cell_count_reg <= cfg_data;
            end
            loaded_reg <= loaded_next;
            sorted_reg <= sorted_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.take)
        begin
            op_reg      <= in_op;
            rd_stat_reg <= rd_stat_next;
        end
    end

    // Particle cell store: written by loads, read at the walk index
    assign pc_we = load_ok;

    ccs_ram #(
        .WIDTH (ccs_pkg::CELL_W),
        .DEPTH (MAX_PARTICLES)
    ) u_pc (
        .clk   (clk),
        .we    (pc_we),
        .waddr (PC_AW'(loaded_reg)),
        .wdata (in_cell),
        .re    (cmd.pc_rd),
        .raddr (PC_AW'(idx_reg)),
        .rdata (pc_rdata)
    );

    // Cell start store: address and data selection
    assign cs_dec = cs_rdata - 1'b1;

    always_comb
    begin
        cs_re    = 1'b0;
        cs_raddr = CS_AW'(idx_reg);
        if (cmd.take && (in_op == ccs_pkg::OP_READ_START))
        begin
            cs_re    = 1'b1;
            cs_raddr = CS_AW'(in_pos);
        end
        else
        begin
            unique case (cmd.cs_rd)
                ccs_pkg::CSR_NONE: cs_re = 1'b0;
                ccs_pkg::CSR_IDX:
                begin
                    cs_re    = 1'b1;
                    cs_raddr = CS_AW'(idx_reg);
                end
                ccs_pkg::CSR_CELL:
                begin
                    cs_re    = 1'b1;
                    cs_raddr = CS_AW'(pc_rdata);
                end
                default: cs_re = 1'b0;
            endcase
        end

        cs_we    = 1'b1;
        cs_waddr = CS_AW'(idx_reg);
        cs_wdata = '0;
        si_we    = 1'b0;
        unique case (cmd.cs_wr)
            ccs_pkg::CSW_NONE: cs_we = 1'b0;
            ccs_pkg::CSW_ZERO: cs_wdata = '0;
            ccs_pkg::CSW_INC:
            begin
                cs_waddr = CS_AW'(pc_rdata);
                cs_wdata = cs_rdata + 1'b1;
            end
            ccs_pkg::CSW_SUM:
            begin
                cs_wdata = sum_reg + cs_rdata;
            end
            ccs_pkg::CSW_TOTAL:
            begin
                cs_waddr = CS_AW'(cell_count_reg);
                cs_wdata = loaded_reg;
            end
            ccs_pkg::CSW_DEC:
            begin
                cs_waddr = CS_AW'(pc_rdata);
                cs_wdata = cs_dec;
                si_we    = 1'b1;
            end
            default: cs_we = 1'b0;
        endcase
    end

    ccs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_CELLS + 1)
    ) u_cs (
        .clk   (clk),
        .we    (cs_we),
        .waddr (cs_waddr),
        .wdata (cs_wdata),
        .re    (cs_re),
        .raddr (cs_raddr),
        .rdata (cs_rdata)
    );

    // Sorted index store: placed during the backward walk
    assign si_re = cmd.take && (in_op == ccs_pkg::OP_READ_SORTED);

    ccs_ram #(
        .WIDTH (PC_AW),
        .DEPTH (MAX_PARTICLES)
    ) u_si (
        .clk   (clk),
        .we    (si_we),
        .waddr (PC_AW'(cs_dec)),
        .wdata (PC_AW'(idx_reg)),
        .re    (si_re),
        .raddr (PC_AW'(in_pos)),
        .rdata (si_rdata)
    );

    // Form the result to push
    always_comb
    begin
        res.value  = '0;
        res.status = ccs_pkg::STAT_OK;
        unique case (cmd.push_kind)
            ccs_pkg::PK_IMM:  res.status = imm_status;
            ccs_pkg::PK_READ:
            begin
                res.status = rd_stat_reg;
                if (rd_stat_reg == ccs_pkg::STAT_OK)
                begin
                    res.value = (op_reg == ccs_pkg::OP_READ_SORTED) ? VW'(si_rdata)
                                                                    : VW'(cs_rdata);
                end
            end
            ccs_pkg::PK_OK:       res.status = ccs_pkg::STAT_OK;
            ccs_pkg::PK_CELL_ERR: res.status = ccs_pkg::STAT_CELL;
            default:              res.status = ccs_pkg::STAT_OK;
        endcase
    end

    // Two-entry result queue: lets a new item in while a result waits
    assign q_pop = out_valid && out_ready;

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (cmd.push && !q_pop)
        begin
            q_cnt_next = q_cnt_reg + 1'b1;
        end
        else if (!cmd.push && q_pop)
        begin
            q_cnt_next = q_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= 1'b0;
            q_rd_reg  <= 1'b0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            if (cmd.push)
            begin
                q_wr_reg <= !q_wr_reg;
            end
            if (q_pop)
            begin
                q_rd_reg <= !q_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            q_mem_reg[q_wr_reg] <= res;
        end
    end

    assign out_valid  = (q_cnt_reg != 2'd0);
    assign out_value  = q_mem_reg[q_rd_reg].value;
    assign out_status = q_mem_reg[q_rd_reg].status;

endmodule

// ===== design/cell_counting_sort.sv =====
// Top level of the cell counting sort block: stream ports, configuration port,
// controller and datapath. Depends on ccs_pkg, ccs_ctrl, ccs_datapath, ccs_ram.
//
// Counting-sort grid builder for spatial hashing. Particle cells are loaded in
// order, a build counts per cell, takes an inclusive prefix sum and places the
// indices walking backwards, leaving each cell's begin offset and the indices
// ascending within a cell. One item is handled at a time; results pass
// through a two-entry queue so a new item is taken while a result waits.
// Steps per item: a load, a no-op or a rejected build is answered from the idle
// state; a read goes through a registered memory read; a clear makes a pass
// that zeroes every cell start entry; a build for n loaded particles and cc
// cells walks check, zero, count, prefix, total and place in that order,
// skipping the walks with nothing to cover, and stops when it meets a bad
// stored cell. After reset the block zeroes the cell start store and takes
// no item meanwhile; configuration writes are taken at any time.
module cell_counting_sort #(
    parameter int MAX_PARTICLES = 4096,
    parameter int MAX_CELLS     = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cell_req [11:0], pos [24:12], zero [31:25]
    input  logic [2:0]  s_tuser,   // op [2:0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value [12:0], zero [15:13]
    output logic [1:0]  m_tuser,   // status [1:0]
    // Cell count register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data   // cell_count [12:0]
);

    ccs_pkg::ccs_cmd_t  cmd;
    ccs_pkg::ccs_stat_t stat;
    logic [ccs_pkg::VALUE_W-1:0] out_value;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    ccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ccs_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_CELLS     (MAX_CELLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_cell    (s_tdata[11:0]),
        .in_pos     (s_tdata[24:12]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_status (m_tuser)
    );

    assign m_tdata = {3'b000, out_value};

endmodule

// ===== design/ccs_checker.sv =====
// Port-level checker for cell_counting_sort, attached by bind.
// Depends on ccs_pkg.
module ccs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A failed operation returns zero
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ccs_pkg::STAT_OK) |-> (m_tdata == 16'd0))
        else $error("non-zero value with error status");

    // A load answers in the next cycle when the queue is empty
    a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ccs_pkg::OP_LOAD) && !m_tvalid |=> m_tvalid)
        else $error("load result late");

    // A clear runs a sweep and takes no item in the next cycle
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ccs_pkg::OP_CLEAR) |=> !s_tready)
        else $error("item taken during clear sweep");

endmodule

bind cell_counting_sort ccs_checker u_checker (.*);
